@@ rtl/core/ppvc_pkg.sv @@
package ppvc_pkg;

   // field and datapath widths
   localparam int POS_W     = 32;
   localparam int QUAT_W    = 16;
   localparam int REG_W     = 31;
   localparam int DIFF_W    = 33;
   localparam int PROD_W    = 2 * REG_W;
   localparam int PROOT_W   = 19;
   localparam int PSQ_W     = 2 * PROOT_W;
   localparam int CW        = 23;
   localparam int ANG_W     = 19;
   localparam int DP_W      = 22;
   localparam int TAIL_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int ATAN_N    = 32;
   localparam int ATAN_W    = 17;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [QUAT_W-1:0] quat_type;
   typedef logic [REG_W-1:0]         reg_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   // register map
   localparam csr_idx_type CSR_MAX_LIN   = 3'd0;
   localparam csr_idx_type CSR_MAX_TURN  = 3'd1;
   localparam csr_idx_type CSR_APP_DIST  = 3'd2;
   localparam csr_idx_type CSR_APP_ANG   = 3'd3;
   localparam csr_idx_type CSR_GOAL_TOL  = 3'd4;

   localparam reg_type RST_MAX_LIN  = 31'd16384;
   localparam reg_type RST_MAX_TURN = 31'd6554;
   localparam reg_type RST_APP_DIST = 31'd16384;
   localparam reg_type RST_APP_ANG  = 31'd6554;
   localparam reg_type RST_GOAL_TOL = 31'd9830;

   // angles in q16.16 radians
   localparam logic signed [DP_W-1:0] Q_PI      = 22'sd205887;
   localparam logic signed [DP_W-1:0] Q_NEG_PI  = -22'sd205887;
   localparam logic signed [DP_W-1:0] Q_TWO_PI  = 22'sd411775;
   localparam logic signed [DP_W-1:0] Q_HALF_PI = 22'sd102944;

   // one in q.28, wide enough for 1 +/- 2s
   localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

   localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_N] = '{
      17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
      17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
      17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
      17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
   };

endpackage

@@ rtl/core/ppvc_isqrt.sv @@
module ppvc_isqrt #(
   parameter int RW = 19
) (
   input  logic            clock,
   input  logic [2*RW-1:0] op,
   output logic [RW-1:0]   root
);

   localparam int OW = 2 * RW;

   logic [RW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [OW-1:0] rest_ff [RW];

   // one root bit per stage, restoring
   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [OW-1:0] rest_prev;
      logic [RW+1:0] shifted;
      logic [RW+1:0] diff;
      logic [RW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = op;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rest_prev = rest_ff[k-1];
      end

      assign shifted = {rem_prev, rest_prev[OW-1:OW-2]};
      assign diff    = shifted - {root_prev, 2'b01};

      always_comb begin
         if (shifted >= {root_prev, 2'b01}) begin
            rem_in  = diff[RW-1:0];
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[RW-1:0];
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rest_ff[k] <= {rest_prev[OW-3:0], 2'b00};
      end
   end

   assign root = root_ff[RW-1];

endmodule

@@ rtl/core/ppvc_div.sv @@
module ppvc_div #(
   parameter int DW = 31,
   parameter int QW = 32
) (
   input  logic             clock,
   input  logic [DW+QW-1:0] num,
   input  logic [DW-1:0]    den,
   output logic [QW-1:0]    quo
);

   localparam int NW = DW + QW;

   // quotient must fit in QW bits: upper numerator bits below the divisor
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] low_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] low_prev;
      logic [DW:0]   shifted;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic          qbit;

      if (k == 0) begin : g_first
         assign rem_prev = num[NW-1:QW];
         assign den_prev = den;
         assign low_prev = num[QW-1:0];
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign low_prev = low_ff[k-1];
      end

      assign shifted = {rem_prev, low_prev[QW-1]};
      assign diff    = shifted - {1'b0, den_prev};
      assign qbit    = ~diff[DW];
      assign rem_in  = qbit ? diff[DW-1:0] : shifted[DW-1:0];

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_prev;
         low_ff[k] <= {low_prev[QW-2:0], qbit};
      end
   end

   assign quo = low_ff[QW-1];

endmodule

@@ rtl/core/pose_proportional_velocity_controller_top.sv @@
// pose proportional velocity controller
// request channel: a transaction is taken on a rising edge with start high and
// busy low; it carries current and goal positions (x, z, q16.16) and current
// and goal orientation quaternions (q2.14)
// response channel: rsp_valid is high for exactly one cycle per transaction,
// with cmd_lin_x, cmd_lin_z, cmd_ang_y (q16.16) and at_goal beside it; the
// receiver has no way to hold a response off
// config: csr_we writes csr_wdata into register csr_index (0 max linear speed,
// 1 max turn rate, 2 approach distance, 3 approach angle, 4 goal tolerance);
// indexes above 4 are dropped; write only while no transaction is in flight
// latency: rsp_valid rises CORDIC_STAGES + 58 cycles after the accepting edge
// and the response is taken at the edge after that (CORDIC_STAGES + 59), set
// by the 19-step pitch root, the cordic chain and the 32-step divide and
// distance root, all fully pipelined
// throughput: one transaction per cycle, back to back, with no stalls anywhere
// reset: synchronous; clears all valid bits, reloads the config defaults and
// holds busy high for one cycle after reset is released
module pose_proportional_velocity_controller_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ppvc_pkg::pos_type     req_cur_pos_x,
   input  ppvc_pkg::pos_type     req_cur_pos_z,
   input  ppvc_pkg::quat_type    req_cur_quat_w,
   input  ppvc_pkg::quat_type    req_cur_quat_x,
   input  ppvc_pkg::quat_type    req_cur_quat_y,
   input  ppvc_pkg::quat_type    req_cur_quat_z,
   input  ppvc_pkg::pos_type     req_goal_pos_x,
   input  ppvc_pkg::pos_type     req_goal_pos_z,
   input  ppvc_pkg::quat_type    req_goal_quat_w,
   input  ppvc_pkg::quat_type    req_goal_quat_x,
   input  ppvc_pkg::quat_type    req_goal_quat_y,
   input  ppvc_pkg::quat_type    req_goal_quat_z,
   output logic                  rsp_valid,
   output ppvc_pkg::pos_type     rsp_cmd_lin_x,
   output ppvc_pkg::pos_type     rsp_cmd_lin_z,
   output ppvc_pkg::pos_type     rsp_cmd_ang_y,
   output logic                  rsp_at_goal,
   input  logic                  csr_we,
   input  ppvc_pkg::csr_idx_type csr_index,
   input  ppvc_pkg::reg_type     csr_wdata
);

   import ppvc_pkg::*;

   localparam int LEN1    = PROOT_W + CORDIC_STAGES;
   localparam int LATENCY = 8 + LEN1 + TAIL_W;

   // sideband that rides along the divide / distance root
   typedef struct packed {
      logic            sat_x;
      logic            pos_x;
      logic            neg_x;
      logic            sat_z;
      logic            pos_z;
      logic            neg_z;
      logic            sat_p;
      logic            pos_p;
      logic            neg_p;
      logic            big;
      logic [DP_W-1:0] adp;
   } tail_type;

   function automatic logic [POS_W-1:0] p_cmd(input logic sat, input logic pos,
                                              input logic neg, input reg_type lim,
                                              input logic [TAIL_W-1:0] quo);
      logic [POS_W-1:0] lim_ext;
      lim_ext = {1'b0, lim};
      if (sat) begin
         if (pos) p_cmd = -lim_ext;
         else if (neg) p_cmd = lim_ext;
         else p_cmd = '0;
      end else if (neg) begin
         p_cmd = quo;
      end else begin
         p_cmd = -quo;
      end
   endfunction

   //--------------------------------------------------------------------------
   // config registers
   reg_type max_lin_ff, max_turn_ff, app_dist_ff, app_ang_ff, goal_tol_ff;
   logic    busy_ff;
   logic    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_ff  <= RST_MAX_LIN;
         max_turn_ff <= RST_MAX_TURN;
         app_dist_ff <= RST_APP_DIST;
         app_ang_ff  <= RST_APP_ANG;
         goal_tol_ff <= RST_GOAL_TOL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_LIN:  max_lin_ff  <= csr_wdata;
            CSR_MAX_TURN: max_turn_ff <= csr_wdata;
            CSR_APP_DIST: app_dist_ff <= csr_wdata;
            CSR_APP_ANG:  app_ang_ff  <= csr_wdata;
            CSR_GOAL_TOL: goal_tol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline never stalls, so busy only covers reset and the cycle after it
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b1;
      else busy_ff <= 1'b0;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   //--------------------------------------------------------------------------
   // stage 0: capture the transaction
   logic     v0_ff;
   pos_type  cpx0_ff, cpz0_ff, gpx0_ff, gpz0_ff;
   quat_type qw0_ff [2];
   quat_type qx0_ff [2];
   quat_type qy0_ff [2];
   quat_type qz0_ff [2];

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cpx0_ff   <= req_cur_pos_x;
         cpz0_ff   <= req_cur_pos_z;
         gpx0_ff   <= req_goal_pos_x;
         gpz0_ff   <= req_goal_pos_z;
         qw0_ff[0] <= req_cur_quat_w;
         qx0_ff[0] <= req_cur_quat_x;
         qy0_ff[0] <= req_cur_quat_y;
         qz0_ff[0] <= req_cur_quat_z;
         qw0_ff[1] <= req_goal_quat_w;
         qx0_ff[1] <= req_goal_quat_x;
         qy0_ff[1] <= req_goal_quat_y;
         qz0_ff[1] <= req_goal_quat_z;
      end
   end

   //--------------------------------------------------------------------------
   // stage 1: quaternion products, position error
   logic                     v1_ff;
   logic signed [POS_W-1:0]  mwy1_ff [2];
   logic signed [POS_W-1:0]  mxz1_ff [2];
   logic signed [DIFF_W-1:0] dx1_ff, dz1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         mwy1_ff[l] <= qw0_ff[l] * qy0_ff[l];
         mxz1_ff[l] <= qx0_ff[l] * qz0_ff[l];
      end
      dx1_ff <= {gpx0_ff[POS_W-1], gpx0_ff} - {cpx0_ff[POS_W-1], cpx0_ff};
      dz1_ff <= {gpz0_ff[POS_W-1], gpz0_ff} - {cpz0_ff[POS_W-1], cpz0_ff};
   end

   //--------------------------------------------------------------------------
   // stage 2: root arguments 16*(1 +/- 2s), negatives clamp to zero
   logic                     v2_ff;
   logic [PSQ_W-1:0]         sa2_ff [2];
   logic [PSQ_W-1:0]         sb2_ff [2];
   logic [PSQ_W-1:0]         sa_in  [2];
   logic [PSQ_W-1:0]         sb_in  [2];
   logic signed [DIFF_W-1:0] dx2_ff, dz2_ff;

   always_comb begin
      logic signed [DIFF_W-1:0] s_val;
      logic signed [34:0]       s_ext;
      logic signed [34:0]       a_val;
      logic signed [34:0]       b_val;
      for (int l = 0; l < 2; l++) begin
         s_val = {mwy1_ff[l][POS_W-1], mwy1_ff[l]} - {mxz1_ff[l][POS_W-1], mxz1_ff[l]};
         s_ext = {{2{s_val[DIFF_W-1]}}, s_val};
         a_val = ONE_Q28 + (s_ext <<< 1);
         b_val = ONE_Q28 - (s_ext <<< 1);
         sa_in[l] = a_val[34] ? '0 : {a_val[33:0], 4'b0000};
         sb_in[l] = b_val[34] ? '0 : {b_val[33:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      sa2_ff <= sa_in;
      sb2_ff <= sb_in;
      dx2_ff <= dx1_ff;
      dz2_ff <= dz1_ff;
   end

   //--------------------------------------------------------------------------
   // pitch roots: y from 1+2s, x from 1-2s, per pose
   logic [PROOT_W-1:0] ry [2];
   logic [PROOT_W-1:0] rx [2];

   for (genvar l = 0; l < 2; l++) begin : g_proot
      ppvc_isqrt #(.RW(PROOT_W)) u_sqrt_y (
         .clock (clock),
         .op    (sa2_ff[l]),
         .root  (ry[l])
      );
      ppvc_isqrt #(.RW(PROOT_W)) u_sqrt_x (
         .clock (clock),
         .op    (sb2_ff[l]),
         .root  (rx[l])
      );
   end

   //--------------------------------------------------------------------------
   // cordic vectoring, one stage per iteration, both poses side by side
   logic signed [CW-1:0]    cx_ff  [CORDIC_STAGES][2];
   logic signed [CW-1:0]    cy_ff  [CORDIC_STAGES][2];
   logic signed [ANG_W-1:0] ang_ff [CORDIC_STAGES][2];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [CW-1:0]    x_prev, y_prev, x_in, y_in;
         logic signed [ANG_W-1:0] a_prev, a_in, step;

         if (i == 0) begin : g_first
            assign x_prev = $signed({{(CW-PROOT_W){1'b0}}, rx[l]});
            assign y_prev = $signed({{(CW-PROOT_W){1'b0}}, ry[l]});
            assign a_prev = '0;
         end else begin : g_next
            assign x_prev = cx_ff[i-1][l];
            assign y_prev = cy_ff[i-1][l];
            assign a_prev = ang_ff[i-1][l];
         end

         assign step = $signed({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[i]});

         // rotate toward the x axis; shifts floor for negative values
         always_comb begin
            if (!y_prev[CW-1]) begin
               x_in = x_prev + (y_prev >>> i);
               y_in = y_prev - (x_prev >>> i);
               a_in = a_prev + step;
            end else begin
               x_in = x_prev - (y_prev >>> i);
               y_in = y_prev + (x_prev >>> i);
               a_in = a_prev - step;
            end
         end

         always_ff @(posedge clock) begin
            cx_ff[i][l]  <= x_in;
            cy_ff[i][l]  <= y_in;
            ang_ff[i][l] <= a_in;
         end
      end
   end

   // position error waits for the pitch path
   logic [LEN1-1:0]          dl1_v_ff;
   logic signed [DIFF_W-1:0] dl1_dx_ff [LEN1];
   logic signed [DIFF_W-1:0] dl1_dz_ff [LEN1];

   always_ff @(posedge clock) begin
      if (reset) dl1_v_ff <= '0;
      else dl1_v_ff <= {dl1_v_ff[LEN1-2:0], v2_ff};
   end

   always_ff @(posedge clock) begin
      dl1_dx_ff[0] <= dx2_ff;
      dl1_dz_ff[0] <= dz2_ff;
      for (int k = 1; k < LEN1; k++) begin
         dl1_dx_ff[k] <= dl1_dx_ff[k-1];
         dl1_dz_ff[k] <= dl1_dz_ff[k-1];
      end
   end

   //--------------------------------------------------------------------------
   // stage w1: pitch difference wrapped once, position error magnitudes
   logic                   vw1_ff;
   logic signed [DP_W-1:0] dpw1_ff;
   logic [DIFF_W-1:0]      adx1_ff, adz1_ff;
   logic                   posx1_ff, negx1_ff, posz1_ff, negz1_ff;
   logic signed [DP_W-1:0] dpw_in;

   always_comb begin
      logic signed [DP_W-1:0] pc;
      logic signed [DP_W-1:0] pg;
      logic signed [DP_W-1:0] dp;
      pc = $signed({{2{ang_ff[CORDIC_STAGES-1][0][ANG_W-1]}},
                    ang_ff[CORDIC_STAGES-1][0], 1'b0}) - Q_HALF_PI;
      pg = $signed({{2{ang_ff[CORDIC_STAGES-1][1][ANG_W-1]}},
                    ang_ff[CORDIC_STAGES-1][1], 1'b0}) - Q_HALF_PI;
      dp = pg - pc;
      if (dp >= Q_PI) dpw_in = dp - Q_TWO_PI;
      else if (dp < Q_NEG_PI) dpw_in = dp + Q_TWO_PI;
      else dpw_in = dp;
   end

   always_ff @(posedge clock) begin
      if (reset) vw1_ff <= 1'b0;
      else vw1_ff <= dl1_v_ff[LEN1-1];
   end

   always_ff @(posedge clock) begin
      dpw1_ff  <= dpw_in;
      adx1_ff  <= dl1_dx_ff[LEN1-1][DIFF_W-1] ? -dl1_dx_ff[LEN1-1] : dl1_dx_ff[LEN1-1];
      adz1_ff  <= dl1_dz_ff[LEN1-1][DIFF_W-1] ? -dl1_dz_ff[LEN1-1] : dl1_dz_ff[LEN1-1];
      negx1_ff <= dl1_dx_ff[LEN1-1][DIFF_W-1];
      negz1_ff <= dl1_dz_ff[LEN1-1][DIFF_W-1];
      posx1_ff <= ~dl1_dx_ff[LEN1-1][DIFF_W-1] && (dl1_dx_ff[LEN1-1] != '0);
      posz1_ff <= ~dl1_dz_ff[LEN1-1][DIFF_W-1] && (dl1_dz_ff[LEN1-1] != '0);
   end

   //--------------------------------------------------------------------------
   // stage w2: saturation decisions, far-off flag
   logic     vw2_ff;
   tail_type sw2_ff;
   reg_type  adx2_ff, adz2_ff;
   tail_type sw2_in;

   always_comb begin
      logic [DP_W-1:0] adp;
      adp = dpw1_ff[DP_W-1] ? -dpw1_ff : dpw1_ff;
      sw2_in.sat_x = adx1_ff >= {2'b00, app_dist_ff};
      sw2_in.pos_x = posx1_ff;
      sw2_in.neg_x = negx1_ff;
      sw2_in.sat_z = adz1_ff >= {2'b00, app_dist_ff};
      sw2_in.pos_z = posz1_ff;
      sw2_in.neg_z = negz1_ff;
      sw2_in.sat_p = {{(REG_W-DP_W){1'b0}}, adp} >= app_ang_ff;
      sw2_in.pos_p = ~dpw1_ff[DP_W-1] && (dpw1_ff != '0);
      sw2_in.neg_p = dpw1_ff[DP_W-1];
      sw2_in.big   = (adx1_ff[DIFF_W-1:REG_W] != '0) || (adz1_ff[DIFF_W-1:REG_W] != '0);
      sw2_in.adp   = adp;
   end

   always_ff @(posedge clock) begin
      if (reset) vw2_ff <= 1'b0;
      else vw2_ff <= vw1_ff;
   end

   always_ff @(posedge clock) begin
      sw2_ff  <= sw2_in;
      adx2_ff <= adx1_ff[REG_W-1:0];
      adz2_ff <= adz1_ff[REG_W-1:0];
   end

   //--------------------------------------------------------------------------
   // stage m: gain products and squared distances
   logic              vm_ff;
   tail_type          sm_ff;
   logic [PROD_W-1:0] prx_ff, prz_ff, prp_ff, sqx_ff, sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else vm_ff <= vw2_ff;
   end

   always_ff @(posedge clock) begin
      sm_ff  <= sw2_ff;
      prx_ff <= max_lin_ff * adx2_ff;
      prz_ff <= max_lin_ff * adz2_ff;
      prp_ff <= max_turn_ff * {{(REG_W-DP_W){1'b0}}, sw2_ff.adp};
      sqx_ff <= adx2_ff * adx2_ff;
      sqz_ff <= adz2_ff * adz2_ff;
   end

   //--------------------------------------------------------------------------
   // stage a: dividend / divisor select, distance sum
   logic                   va_ff;
   tail_type               sa_ff;
   logic [PROD_W:0]        numx_ff, numz_ff, nump_ff;
   reg_type                denx_ff, denz_ff, denp_ff;
   logic [2*TAIL_W-1:0]    sq_ff;

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= vm_ff;
   end

   // a saturated lane gets a harmless 0/1 divide, its quotient is ignored
   always_ff @(posedge clock) begin
      sa_ff   <= sm_ff;
      numx_ff <= sm_ff.sat_x ? '0 : {1'b0, prx_ff};
      numz_ff <= sm_ff.sat_z ? '0 : {1'b0, prz_ff};
      nump_ff <= sm_ff.sat_p ? '0 : {1'b0, prp_ff};
      denx_ff <= sm_ff.sat_x ? 31'd1 : app_dist_ff;
      denz_ff <= sm_ff.sat_z ? 31'd1 : app_dist_ff;
      denp_ff <= sm_ff.sat_p ? 31'd1 : app_ang_ff;
      sq_ff   <= {2'b00, sqx_ff} + {2'b00, sqz_ff};
   end

   //--------------------------------------------------------------------------
   // tail: three dividers and the distance root, equal latency
   logic [TAIL_W-1:0] quo_x, quo_z, quo_p, dist_root;

   ppvc_div #(.DW(REG_W), .QW(TAIL_W)) u_div_x (
      .clock (clock),
      .num   (numx_ff),
      .den   (denx_ff),
      .quo   (quo_x)
   );

   ppvc_div #(.DW(REG_W), .QW(TAIL_W)) u_div_z (
      .clock (clock),
      .num   (numz_ff),
      .den   (denz_ff),
      .quo   (quo_z)
   );

   ppvc_div #(.DW(REG_W), .QW(TAIL_W)) u_div_p (
      .clock (clock),
      .num   (nump_ff),
      .den   (denp_ff),
      .quo   (quo_p)
   );

   ppvc_isqrt #(.RW(TAIL_W)) u_dist (
      .clock (clock),
      .op    (sq_ff),
      .root  (dist_root)
   );

   logic [TAIL_W-1:0] dl2_v_ff;
   tail_type          dl2_ff [TAIL_W];

   always_ff @(posedge clock) begin
      if (reset) dl2_v_ff <= '0;
      else dl2_v_ff <= {dl2_v_ff[TAIL_W-2:0], va_ff};
   end

   always_ff @(posedge clock) begin
      dl2_ff[0] <= sa_ff;
      for (int k = 1; k < TAIL_W; k++) begin
         dl2_ff[k] <= dl2_ff[k-1];
      end
   end

   //--------------------------------------------------------------------------
   // output stage: sign, clamp and goal test
   tail_type          st;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  cmd_x_ff, cmd_z_ff, cmd_p_ff;
   logic              at_goal_ff;
   logic              at_goal_in;

   assign st         = dl2_ff[TAIL_W-1];
   assign at_goal_in = ~st.big &&
                       (({1'b0, dist_root} + {{(TAIL_W+1-DP_W){1'b0}}, st.adp}) <
                        {{(TAIL_W+1-REG_W){1'b0}}, goal_tol_ff});

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= dl2_v_ff[TAIL_W-1];
   end

   always_ff @(posedge clock) begin
      cmd_x_ff   <= p_cmd(st.sat_x, st.pos_x, st.neg_x, max_lin_ff, quo_x);
      cmd_z_ff   <= p_cmd(st.sat_z, st.pos_z, st.neg_z, max_lin_ff, quo_z);
      cmd_p_ff   <= p_cmd(st.sat_p, st.pos_p, st.neg_p, max_turn_ff, quo_p);
      at_goal_ff <= at_goal_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cmd_lin_x = cmd_x_ff;
   assign rsp_cmd_lin_z = cmd_z_ff;
   assign rsp_cmd_ang_y = cmd_p_ff;
   assign rsp_at_goal   = at_goal_ff;

   //--------------------------------------------------------------------------
   // every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("response missing after fixed latency");

   // once ready, the block stays ready until the next reset
   a_busy_low: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy rose outside reset");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

@@ tb/tb_pose_proportional_velocity_controller_top.sv @@
module tb_pose_proportional_velocity_controller_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppvc_pkg::*;

   localparam int STAGES    = 16;
   localparam int LATENCY   = STAGES + 58;
   localparam int WATCHDOG  = 20000;
   localparam int N_RANDOM  = 1250;

   // expected command set for one transaction
   typedef struct packed {
      logic signed [31:0] lin_x;
      logic signed [31:0] lin_z;
      logic signed [31:0] ang_y;
      logic               at_goal;
   } cmd_set_type;

   typedef struct {
      pos_type  cx, cz, gx, gz;
      quat_type cw, cqx, cqy, cqz, gw, gqx, gqy, gqz;
   } pose_pair_type;

   // scoreboard: predicts commands from gains held in its own copy of the registers
   class cmd_scoreboard;
      longint      gain_lin, gain_turn, app_dist, app_ang, tol;
      cmd_set_type pending[$];
      int          errors;

      function void reset_regs();
         gain_lin  = RST_MAX_LIN;
         gain_turn = RST_MAX_TURN;
         app_dist  = RST_APP_DIST;
         app_ang   = RST_APP_ANG;
         tol       = RST_GOAL_TOL;
      endfunction

      function void write_reg(csr_idx_type idx, reg_type val);
         case (idx)
            CSR_MAX_LIN:  gain_lin  = val;
            CSR_MAX_TURN: gain_turn = val;
            CSR_APP_DIST: app_dist  = val;
            CSR_APP_ANG:  app_ang   = val;
            CSR_GOAL_TOL: tol       = val;
            default: ;
         endcase
      endfunction

      function longint isqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return longint'(r);
      endfunction

      function longint pitch(quat_type w, quat_type x, quat_type y, quat_type z);
         longint s, a, b, vy, vx, nx, ny, ang;
         s = longint'(w) * longint'(y) - longint'(x) * longint'(z);
         a = (64'sd1 <<< 28) + 2 * s;
         b = (64'sd1 <<< 28) - 2 * s;
         if (a < 0) a = 0;
         if (b < 0) b = 0;
         vy  = isqrt(a * 16);
         vx  = isqrt(b * 16);
         ang = 0;
         for (int i = 0; i < STAGES && i < 32; i++) begin
            if (vy >= 0) begin
               nx = vx + (vy >>> i);
               ny = vy - (vx >>> i);
               ang += longint'(ATAN_TABLE[i]);
            end else begin
               nx = vx - (vy >>> i);
               ny = vy + (vx >>> i);
               ang -= longint'(ATAN_TABLE[i]);
            end
            vx = nx;
            vy = ny;
         end
         return 2 * ang - longint'(Q_HALF_PI);
      endfunction

      function longint p_cmd(longint err, longint lim, longint app);
         longint mag;
         mag = err < 0 ? -err : err;
         if (mag >= app) begin
            if (err > 0) return -lim;
            if (err < 0) return lim;
            return 0;
         end
         return -(lim * err) / app;
      endfunction

      function void note_pose(pose_pair_type p);
         longint      dx, dz, dp, ax, az;
         cmd_set_type c;
         dx = longint'(p.gx) - longint'(p.cx);
         dz = longint'(p.gz) - longint'(p.cz);
         dp = pitch(p.gw, p.gqx, p.gqy, p.gqz) - pitch(p.cw, p.cqx, p.cqy, p.cqz);
         if (dp >= longint'(Q_PI)) dp -= longint'(Q_TWO_PI);
         else if (dp < -longint'(Q_PI)) dp += longint'(Q_TWO_PI);
         c.lin_x = 32'(p_cmd(dx, gain_lin, app_dist));
         c.lin_z = 32'(p_cmd(dz, gain_lin, app_dist));
         c.ang_y = 32'(p_cmd(dp, gain_turn, app_ang));
         ax = dx < 0 ? -dx : dx;
         az = dz < 0 ? -dz : dz;
         c.at_goal = 1'b0;
         if (ax < (64'sd1 <<< 31) && az < (64'sd1 <<< 31))
            c.at_goal = isqrt(ax * ax + az * az) + (dp < 0 ? -dp : dp) < tol;
         pending.push_back(c);
      endfunction

      function void check_cmd(cmd_set_type got);
         cmd_set_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.lin_x !== e.lin_x) begin
            $display("%0t lin_x exp %0d got %0d", $realtime, e.lin_x, got.lin_x);
            errors++;
         end
         if (got.lin_z !== e.lin_z) begin
            $display("%0t lin_z exp %0d got %0d", $realtime, e.lin_z, got.lin_z);
            errors++;
         end
         if (got.ang_y !== e.ang_y) begin
            $display("%0t ang_y exp %0d got %0d", $realtime, e.ang_y, got.ang_y);
            errors++;
         end
         if (got.at_goal !== e.at_goal) begin
            $display("%0t at_goal exp %0b got %0b", $realtime, e.at_goal, got.at_goal);
            errors++;
         end
      endfunction
   endclass

   logic          clock, reset, start, busy, rsp_valid, rsp_at_goal, csr_we;
   pose_pair_type drv;
   pos_type       rsp_cmd_lin_x, rsp_cmd_lin_z, rsp_cmd_ang_y;
   csr_idx_type   csr_index;
   reg_type       csr_wdata;
   cmd_scoreboard sb;
   int            idle_cycles;

   pose_proportional_velocity_controller_top #(.CORDIC_STAGES(STAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cur_pos_x(drv.cx), .req_cur_pos_z(drv.cz),
      .req_cur_quat_w(drv.cw), .req_cur_quat_x(drv.cqx),
      .req_cur_quat_y(drv.cqy), .req_cur_quat_z(drv.cqz),
      .req_goal_pos_x(drv.gx), .req_goal_pos_z(drv.gz),
      .req_goal_quat_w(drv.gw), .req_goal_quat_x(drv.gqx),
      .req_goal_quat_y(drv.gqy), .req_goal_quat_z(drv.gqz),
      .rsp_valid(rsp_valid), .rsp_cmd_lin_x(rsp_cmd_lin_x),
      .rsp_cmd_lin_z(rsp_cmd_lin_z), .rsp_cmd_ang_y(rsp_cmd_ang_y),
      .rsp_at_goal(rsp_at_goal),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor: a response is live for one cycle only, so sample every rising edge;
   // the watchdog counts edges with neither a request nor a response taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_cmd({rsp_cmd_lin_x, rsp_cmd_lin_z, rsp_cmd_ang_y, rsp_at_goal});
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   // a random quaternion component, extremes and out-of-range values included
   function automatic quat_type rand_quat();
      case ($urandom_range(0, 5))
         0: return quat_type'(16384);
         1: return quat_type'(-16384);
         2: return quat_type'(0);
         3: return quat_type'($urandom);
         default: return quat_type'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // positions mostly near each other so that the proportional and at-goal paths show up
   function automatic pos_type rand_pos();
      if ($urandom_range(0, 3) == 0) return pos_type'($urandom);
      return pos_type'($urandom_range(0, 8192) - 4096);
   endfunction

   function automatic pose_pair_type rand_pose();
      pose_pair_type p;
      p.cx = rand_pos();
      p.cz = rand_pos();
      p.gx = ($urandom_range(0, 3) == 0) ? pos_type'($urandom) : p.cx + rand_pos();
      p.gz = ($urandom_range(0, 3) == 0) ? pos_type'($urandom) : p.cz + rand_pos();
      p.cw = rand_quat(); p.cqx = rand_quat(); p.cqy = rand_quat(); p.cqz = rand_quat();
      if ($urandom_range(0, 2) == 0) begin
         // goal orientation equal to the current one
         p.gw = p.cw; p.gqx = p.cqx; p.gqy = p.cqy; p.gqz = p.cqz;
      end else begin
         p.gw = rand_quat(); p.gqx = rand_quat(); p.gqy = rand_quat(); p.gqz = rand_quat();
      end
      return p;
   endfunction

   // drive one transaction and hold it until the block takes it; start stays
   // high so that the next call can follow in the very next cycle
   task automatic send_pose(pose_pair_type p);
      @(negedge clock);
      drv   = p;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_pose(p);
   endtask

   // end a run of back-to-back transactions
   task automatic stop_send();
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_csr(csr_idx_type idx, reg_type val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait out everything in flight before touching the registers
   task automatic drain();
      stop_send();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_burst(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         int len;
         len = $urandom_range(1, 12);
         for (int k = 0; k < len && sent < count; k++) begin
            send_pose(rand_pose());
            sent++;
         end
         // gaps of random length, sometimes none at all
         if ($urandom_range(0, 2) != 0) begin
            stop_send();
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
      end
   endtask

   function automatic reg_type rand_reg(bit nonzero);
      reg_type v;
      case ($urandom_range(0, 4))
         0: v = 31'h7FFF_FFFF;
         1: v = nonzero ? 31'd1 : 31'd0;
         2: v = reg_type'($urandom);
         default: v = reg_type'($urandom_range(1, 200000));
      endcase
      return v;
   endfunction

   initial begin
      pose_pair_type p;
      sb = new();
      sb.reset_regs();
      idle_cycles = 0;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_LIN;
      csr_wdata = '0;
      drv = '{default: '0};
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero error, field extremes, saturation both ways, wrap of pitch
      p = '{default: '0};
      p.cw = 16384; p.gw = 16384;
      send_pose(p);
      p.cx = 32'sh8000_0000; p.gx = 32'sh7FFF_FFFF;
      p.cz = 32'sh7FFF_FFFF; p.gz = 32'sh8000_0000;
      send_pose(p);
      p.cx = 100; p.gx = 50; p.cz = -20; p.gz = 30;
      send_pose(p);
      // pitch near +pi/2 against near -pi/2 exercises the wrap
      p.cw = 16384; p.cqy = 16384; p.gw = 16384; p.gqy = -16384;
      send_pose(p);
      p.cw = -16384; p.cqx = 16384; p.cqy = -16384; p.cqz = -16384;
      p.gw = 16384; p.gqx = -16384; p.gqy = 16384; p.gqz = 16384;
      send_pose(p);
      p.cw = -16'sd32768; p.cqx = 16'sd32767; p.cqy = -16'sd32768; p.cqz = -16'sd32768;
      p.gw = 16'sd32767; p.gqx = -16'sd1; p.gqy = 16'sd32767; p.gqz = 16'sd32767;
      send_pose(p);
      p = '{default: '0};
      p.cx = 32'sh0000_1000; p.gx = 32'sh0000_1001;
      send_pose(p);
      p.cx = -1; p.gx = 0; p.cz = 0; p.gz = -1;
      send_pose(p);
      for (int k = 0; k < 8; k++) send_pose(rand_pose());

      // pause until every response has come back
      drain();

      // zero approach and zero gain, then full-scale registers
      write_csr(CSR_APP_DIST, '0);
      write_csr(CSR_APP_ANG, '0);
      write_csr(CSR_MAX_LIN, '0);
      write_csr(CSR_GOAL_TOL, 31'h7FFF_FFFF);
      write_csr(3'd7, 31'd5);
      p = '{default: '0};
      send_pose(p);
      p.gx = 1; p.cw = 16384; p.gqy = 16384;
      send_pose(p);
      random_burst(40);
      drain();
      write_csr(CSR_MAX_LIN, 31'h7FFF_FFFF);
      write_csr(CSR_MAX_TURN, 31'h7FFF_FFFF);
      write_csr(CSR_APP_DIST, 31'h7FFF_FFFF);
      write_csr(CSR_APP_ANG, 31'h7FFF_FFFF);
      write_csr(CSR_GOAL_TOL, '0);
      random_burst(60);
      drain();
      write_csr(CSR_APP_DIST, 31'd1);
      write_csr(CSR_APP_ANG, 31'd1);
      write_csr(CSR_GOAL_TOL, 31'd1);
      random_burst(40);

      // random phases, each with a fresh register setting
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         write_csr(CSR_MAX_LIN, rand_reg(0));
         write_csr(CSR_MAX_TURN, rand_reg(0));
         write_csr(CSR_APP_DIST, rand_reg(1));
         write_csr(CSR_APP_ANG, rand_reg(1));
         write_csr(CSR_GOAL_TOL, rand_reg(0));
         random_burst(N_RANDOM / 10 - 10);
      end

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ pose_proportional_velocity_controller_top.f @@
rtl/core/ppvc_pkg.sv
rtl/core/ppvc_isqrt.sv
rtl/core/ppvc_div.sv
rtl/core/pose_proportional_velocity_controller_top.sv
tb/tb_pose_proportional_velocity_controller_top.sv
